// File: rtl/rrli_pkg.sv
// ----------------------------------------------------------------------------
// rrli_pkg
// shared constants, command codes and types of the ring resampler
// ----------------------------------------------------------------------------
`default_nettype none

package rrli_pkg;

   // ring of stereo frames
   localparam int RING_FRAMES = 4096;
   localparam int ADDR_W      = 12;
   localparam int DIST_W      = ADDR_W + 1;
   localparam int CNT_W       = 48;
   localparam int SAMPLE_W    = 16;
   localparam int FRAME_W     = 2 * SAMPLE_W;

   // position format
   localparam int FRAC_BITS_DEF = 16;
   localparam int STEP_Q_BITS   = 16;
   localparam int FRAC_MAX      = 24;

   // commands
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // control registers
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int STEP_CSR_W  = 19;
   localparam int DELAY_CSR_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY = 2'd1;
   localparam logic [STEP_CSR_W-1:0]  STEP_RESET  = 19'd60211;
   localparam logic [DELAY_CSR_W-1:0] DELAY_RESET = 13'd1024;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic ok;
      logic resync;
   } rd_info_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                valid_res;
      logic                resynced;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: rtl/ring_resampler_linear_interp.sv
// a read word's result passes the position phases, the registered frame memory
// read, the product stage and the result queue before it is offered
// a read word holds off input during its position update, then both ring reads
// are made in one access of the frame memory; input also stalls while 4 read
// words are outstanding; reset is synchronous, and afterwards the frame memory
// is cleared to zero one frame a cycle, with input stalled meanwhile
// ----------------------------------------------------------------------------
// ring_resampler_linear_interp
// stereo frame ring with fractional read head and linear interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module ring_resampler_linear_interp #(
   parameter int FRAC_BITS = rrli_pkg::FRAC_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire        [1:0]                      req_command,
   input  wire signed [rrli_pkg::SAMPLE_W-1:0]   req_left_in,
   input  wire signed [rrli_pkg::SAMPLE_W-1:0]   req_right_in,
   input  wire                                   req_silent,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [rrli_pkg::SAMPLE_W-1:0]  rsp_left_out,
   output logic signed [rrli_pkg::SAMPLE_W-1:0]  rsp_right_out,
   output logic                                  rsp_valid_res,
   output logic                                  rsp_resynced,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire        [rrli_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire        [rrli_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W   = rrli_pkg::CNT_W;
   localparam int ADDR_W  = rrli_pkg::ADDR_W;
   localparam int DIST_W  = rrli_pkg::DIST_W;
   localparam int STEP_W  = FRAC_BITS + 3;
   localparam int NEED_W  = STEP_W + 1;
   localparam int AVAIL_W = DIST_W + FRAC_BITS + 1;
   localparam int PAD_W   = rrli_pkg::FRAC_MAX - rrli_pkg::STEP_Q_BITS;
   localparam int WIDE_W  = rrli_pkg::STEP_CSR_W + PAD_W;
   localparam int SHIFT   = rrli_pkg::FRAC_MAX - FRAC_BITS;
   localparam logic [DIST_W-1:0] RING = DIST_W'(rrli_pkg::RING_FRAMES);

   // control registers
   logic [rrli_pkg::STEP_CSR_W-1:0]  step_ff;
   logic [rrli_pkg::DELAY_CSR_W-1:0] delay_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= rrli_pkg::STEP_RESET;
         delay_ff <= rrli_pkg::DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rrli_pkg::CSR_STEP) begin
            step_ff <= csr_wdata[rrli_pkg::STEP_CSR_W-1:0];
         end else if (csr_index == rrli_pkg::CSR_DELAY) begin
            delay_ff <= csr_wdata[rrli_pkg::DELAY_CSR_W-1:0];
         end
      end
   end

   // state
   logic                            clr_ff;
   logic [ADDR_W-1:0]               clr_addr_ff;
   logic                            phase0_ff, phase1_ff;
   logic [CNT_W-1:0]                wr_cnt_ff, rd_int_ff;
   logic [FRAC_BITS-1:0]            rd_frac_ff;
   logic                            primed_ff, resync_ff;
   logic [DIST_W-1:0]               dist_ff;
   logic [rrli_pkg::RSP_CNT_W-1:0]  credit_ff, credit_in;

   logic req_accept, rd_accept, rsp_pop;

   assign req_stall  = clr_ff | phase0_ff
                     | (credit_ff == rrli_pkg::RSP_CNT_W'(rrli_pkg::RSP_DEPTH));
   assign req_accept = req_valid & ~req_stall;
   assign rd_accept  = req_accept & (req_command == rrli_pkg::CMD_READ);
   assign rsp_pop    = rsp_valid & ~rsp_stall;
   assign credit_in  = credit_ff + rrli_pkg::RSP_CNT_W'(rd_accept)
                               - rrli_pkg::RSP_CNT_W'(rsp_pop);

   // resync decision
   logic              ahead, far, resync, w_gt_t;
   logic [CNT_W-1:0]  diff, new_ri;
   logic [DIST_W-1:0] tgt, dist_in;

   always_comb begin
      ahead  = (rd_int_ff > wr_cnt_ff)
             || ((rd_int_ff == wr_cnt_ff) && (rd_frac_ff != '0));
      diff   = wr_cnt_ff - rd_int_ff;
      far    = diff > CNT_W'(RING);
      resync = ~primed_ff | ahead | far;
      tgt    = (delay_ff > RING) ? RING : delay_ff;
      w_gt_t = wr_cnt_ff > CNT_W'(tgt);
      new_ri = w_gt_t ? (wr_cnt_ff - CNT_W'(tgt)) : '0;
      if (resync) begin
         dist_in = w_gt_t ? tgt : wr_cnt_ff[DIST_W-1:0];
      end else begin
         dist_in = diff[DIST_W-1:0];
      end
   end

   // availability and advance
   logic [WIDE_W-1:0]  stp_wide;
   logic [STEP_W-1:0]  stp;
   logic [NEED_W-1:0]  need, adv;
   logic [AVAIL_W-1:0] avail;
   logic               rd_ok;

   always_comb begin
      stp_wide = {step_ff, PAD_W'(0)} >> SHIFT;
      stp      = stp_wide[STEP_W-1:0];
      need     = NEED_W'(stp) + (NEED_W'(1) << FRAC_BITS);
      avail    = (AVAIL_W'(dist_ff) << FRAC_BITS) - AVAIL_W'(rd_frac_ff);
      rd_ok    = avail >= AVAIL_W'(need);
      adv      = NEED_W'(stp) + NEED_W'(rd_frac_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         phase0_ff   <= 1'b0;
         phase1_ff   <= 1'b0;
         wr_cnt_ff   <= '0;
         rd_int_ff   <= '0;
         rd_frac_ff  <= '0;
         primed_ff   <= 1'b0;
         credit_ff   <= '0;
      end else begin
         credit_ff <= credit_in;
         phase0_ff <= rd_accept;
         phase1_ff <= phase0_ff;
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(rrli_pkg::RING_FRAMES - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (req_accept && (req_command == rrli_pkg::CMD_WRITE)) begin
            wr_cnt_ff <= wr_cnt_ff + 1'b1;
         end
         if (req_accept && (req_command == rrli_pkg::CMD_RESTART)) begin
            primed_ff <= 1'b0;
         end
         if (phase0_ff) begin
            primed_ff <= 1'b1;
            if (resync) begin
               rd_int_ff  <= new_ri;
               rd_frac_ff <= '0;
            end
         end else if (phase1_ff && rd_ok) begin
            rd_int_ff  <= rd_int_ff + CNT_W'(adv[NEED_W-1:FRAC_BITS]);
            rd_frac_ff <= adv[FRAC_BITS-1:0];
         end
      end
      if (phase0_ff) begin
         resync_ff <= resync;
         dist_ff   <= dist_in;
      end
   end

   // frame memory: one write port, two registered read ports
   logic [rrli_pkg::FRAME_W-1:0] frame_mem [rrli_pkg::RING_FRAMES];
   logic                         mem_we;
   logic [ADDR_W-1:0]            mem_wa, rd_a, rd_b;
   logic [rrli_pkg::FRAME_W-1:0] mem_wd, q_a_ff, q_b_ff;
   logic                         q_vld_ff;
   rrli_pkg::rd_info_type        q_info_ff;
   logic [FRAC_BITS-1:0]         q_frac_ff;

   always_comb begin
      mem_we = clr_ff | (req_accept & (req_command == rrli_pkg::CMD_WRITE));
      mem_wa = clr_ff ? clr_addr_ff : wr_cnt_ff[ADDR_W-1:0];
      if (clr_ff || req_silent) begin
         mem_wd = '0;
      end else begin
         mem_wd = {req_left_in, req_right_in};
      end
      rd_a = rd_int_ff[ADDR_W-1:0];
      rd_b = rd_a + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
      if (phase1_ff) begin
         q_a_ff <= frame_mem[rd_a];
         q_b_ff <= frame_mem[rd_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= phase1_ff;
      end
      q_info_ff.ok     <= rd_ok;
      q_info_ff.resync <= resync_ff;
      q_frac_ff        <= rd_frac_ff;
   end

   rrli_interp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_interp (
      .clock         (clock),
      .reset         (reset),
      .in_vld        (q_vld_ff),
      .in_info       (q_info_ff),
      .in_frac       (q_frac_ff),
      .in_a          (q_a_ff),
      .in_b          (q_b_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_valid_res (rsp_valid_res),
      .rsp_resynced  (rsp_resynced)
   );

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= rrli_pkg::RSP_CNT_W'(rrli_pkg::RSP_DEPTH))
      else $error("read credits exceed result queue depth");

   a_read_phases: assert property (@(posedge clock) disable iff (reset)
      rd_accept |=> phase0_ff ##1 phase1_ff)
      else $error("read word did not pass both position phases");

   a_rsp_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (credit_ff != '0))
      else $error("result offered without a held credit");

   a_issue_dist: assert property (@(posedge clock) disable iff (reset)
      (phase1_ff && rd_ok) |-> (dist_ff != '0))
      else $error("interpolation issued with no source frame available");
`endif

endmodule

`default_nettype wire

// File: rtl/rrli_interp.sv
// ----------------------------------------------------------------------------
// rrli_interp
// two-stage stereo linear interpolation and result queue
// ----------------------------------------------------------------------------
`default_nettype none

module rrli_interp #(
   parameter int FRAC_BITS = rrli_pkg::FRAC_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_vld,
   input  wire rrli_pkg::rd_info_type            in_info,
   input  wire        [FRAC_BITS-1:0]            in_frac,
   input  wire        [rrli_pkg::FRAME_W-1:0]    in_a,
   input  wire        [rrli_pkg::FRAME_W-1:0]    in_b,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [rrli_pkg::SAMPLE_W-1:0]  rsp_left_out,
   output logic signed [rrli_pkg::SAMPLE_W-1:0]  rsp_right_out,
   output logic                                  rsp_valid_res,
   output logic                                  rsp_resynced
);

   localparam int SW = rrli_pkg::SAMPLE_W;
   localparam int DW = SW + 1;
   localparam int PW = DW + FRAC_BITS + 1;

   // product stage
   logic                  p_vld_ff;
   rrli_pkg::rd_info_type p_info_ff;
   logic signed [SW-1:0]  p_al_ff, p_ar_ff;
   logic signed [PW-1:0]  p_pl_ff, p_pr_ff;

   logic signed [SW-1:0]  al, ar, bl, br;
   logic signed [DW-1:0]  dl, dr;
   logic signed [FRAC_BITS:0] frac_s;

   assign al = $signed(in_a[rrli_pkg::FRAME_W-1:SW]);
   assign ar = $signed(in_a[SW-1:0]);
   assign bl = $signed(in_b[rrli_pkg::FRAME_W-1:SW]);
   assign br = $signed(in_b[SW-1:0]);
   assign dl = DW'(bl) - DW'(al);
   assign dr = DW'(br) - DW'(ar);
   assign frac_s = $signed({1'b0, in_frac});

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= in_vld;
      end
      p_info_ff <= in_info;
      p_al_ff   <= al;
      p_ar_ff   <= ar;
      p_pl_ff   <= PW'(dl) * PW'(frac_s);
      p_pr_ff   <= PW'(dr) * PW'(frac_s);
   end

   // floor and add
   logic signed [PW-1:0]   sum_l, sum_r;
   rrli_pkg::rsp_word_type push_word;

   assign sum_l = PW'(p_al_ff) + (p_pl_ff >>> FRAC_BITS);
   assign sum_r = PW'(p_ar_ff) + (p_pr_ff >>> FRAC_BITS);

   always_comb begin
      push_word.left      = p_info_ff.ok ? sum_l[SW-1:0] : '0;
      push_word.right     = p_info_ff.ok ? sum_r[SW-1:0] : '0;
      push_word.valid_res = p_info_ff.ok;
      push_word.resynced  = p_info_ff.resync;
   end

   // result queue, never overflows because the top level holds credits
   rrli_pkg::rsp_word_type          q_mem [rrli_pkg::RSP_DEPTH];
   logic [rrli_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [rrli_pkg::RSP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            pop;
   rrli_pkg::rsp_word_type          head;

   assign pop    = rsp_valid & ~rsp_stall;
   assign cnt_in = cnt_ff + rrli_pkg::RSP_CNT_W'(p_vld_ff)
                          - rrli_pkg::RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (p_vld_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
      if (p_vld_ff) begin
         q_mem[wr_ptr_ff] <= push_word;
      end
   end

   assign head          = q_mem[rd_ptr_ff];
   assign rsp_valid     = (cnt_ff != '0);
   assign rsp_left_out  = $signed(head.left);
   assign rsp_right_out = $signed(head.right);
   assign rsp_valid_res = head.valid_res;
   assign rsp_resynced  = head.resynced;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stereo ring resampler. A short directed run
// covers start-up underruns, sample extremes, silent frames, restart and an
// unknown command. Register sweeps follow, covering the smallest and the largest
// step and delay, with random traffic and random idling on one or both channels.
// A closing run with no idling saturates the delay to a full ring and sends
// words back to back. Every read word is predicted in the bench and each
// result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import rrli_pkg::*;

   localparam int         FRAC        = FRAC_BITS_DEF;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int         SETTLE      = 8;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         SWEEP_WORDS = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_command = CMD_WRITE;
   logic signed [SAMPLE_W-1:0] req_left_in  = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic                       req_silent   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       rsp_valid_res;
   logic                       rsp_resynced;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_STEP;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // bench copy of the ring, the heads and the registers
   logic signed [SAMPLE_W-1:0] ring_left  [0:RING_FRAMES-1];
   logic signed [SAMPLE_W-1:0] ring_right [0:RING_FRAMES-1];
   logic [CNT_W-1:0]           wr_count;
   logic [63:0]                rd_whole;
   logic [FRAC-1:0]            rd_frac;
   logic                       primed;
   logic [STEP_CSR_W-1:0]      step_reg;
   logic [DELAY_CSR_W-1:0]     delay_reg;

   rsp_word_type due_frames [$];
   int fail_count  = 0;
   int cycle_count = 0;
   int gap_pct     = 0;
   int stall_pct   = 0;

   ring_resampler_linear_interp dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .req_silent    (req_silent),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_valid_res (rsp_valid_res),
      .rsp_resynced  (rsp_resynced),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] step_fixed();
      return 64'(step_reg) << (FRAC - STEP_Q_BITS);
   endfunction

   // a + floor((b - a) * frac / 2^FRAC)
   function automatic logic signed [SAMPLE_W-1:0] interp(input logic signed [SAMPLE_W-1:0] a,
         input logic signed [SAMPLE_W-1:0] b, input logic [FRAC-1:0] frac);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'({1'b0, frac});
      return SAMPLE_W'(longint'(a) + (prod >>> FRAC));
   endfunction

   function automatic rsp_word_type predict_read();
      rsp_word_type      res;
      logic [63:0]       w;
      logic [63:0]       t;
      logic [63:0]       sum;
      logic [ADDR_W-1:0] slot;
      logic [ADDR_W-1:0] slot_next;
      logic              ahead;
      res   = '0;
      w     = 64'(wr_count);
      ahead = (rd_whole > w) || (rd_whole == w && rd_frac != '0);
      if (!primed || ahead || (w - rd_whole) > 64'(RING_FRAMES)) begin
         t = (64'(delay_reg) > 64'(RING_FRAMES)) ? 64'(RING_FRAMES) : 64'(delay_reg);
         rd_whole = (w > t) ? w - t : '0;
         rd_frac  = '0;
         primed   = 1'b1;
         res.resynced = 1'b1;
      end
      if ((((w - rd_whole) << FRAC) - 64'(rd_frac)) >= step_fixed() + (64'd1 << FRAC)) begin
         slot      = rd_whole[ADDR_W-1:0];
         slot_next = slot + 1'b1;
         res.left      = interp(ring_left[slot], ring_left[slot_next], rd_frac);
         res.right     = interp(ring_right[slot], ring_right[slot_next], rd_frac);
         res.valid_res = 1'b1;
         sum      = 64'(rd_frac) + step_fixed();
         rd_whole = rd_whole + (sum >> FRAC);
         rd_frac  = sum[FRAC-1:0];
      end
      return res;
   endfunction

   // true when a read now would give a frame, or would resync first
   function automatic logic read_would_fill();
      logic [63:0] span;
      span = 64'(wr_count) - rd_whole;
      if (!primed || span > 64'(RING_FRAMES))
         return 1'b1;
      return ((span << FRAC) - 64'(rd_frac)) >= step_fixed() + (64'd1 << FRAC);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] left,
         input logic [SAMPLE_W-1:0] right, input logic sil);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_left_in  <= left;
      req_right_in <= right;
      req_silent   <= sil;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (cmd)
         CMD_WRITE: begin
            ring_left[wr_count[ADDR_W-1:0]]  = sil ? '0 : left;
            ring_right[wr_count[ADDR_W-1:0]] = sil ? '0 : right;
            wr_count = wr_count + 1'b1;
         end
         CMD_READ:    due_frames.push_back(predict_read());
         CMD_RESTART: primed = 1'b0;
         default: ;
      endcase
   endtask

   task automatic send_random_word();
      int         roll;
      logic [1:0] cmd;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         cmd = CMD_UNKNOWN;
      else if (roll < 5)
         cmd = CMD_RESTART;
      else if (roll < 12)
         cmd = CMD_READ;
      else if (read_would_fill())
         cmd = (roll < 75) ? CMD_READ : CMD_WRITE;
      else
         cmd = (roll < 90) ? CMD_WRITE : CMD_READ;
      send_word(cmd, pick_sample(), pick_sample(), $urandom_range(0, 9) == 0);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (due_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // both registers, with junk above each register's width
   task automatic set_config(input logic [STEP_CSR_W-1:0] step,
         input logic [DELAY_CSR_W-1:0] delay);
      logic [CSR_DATA_W-1:0] step_word;
      logic [CSR_DATA_W-1:0] delay_word;
      step_word  = $urandom;
      delay_word = $urandom;
      step_word[STEP_CSR_W-1:0]   = step;
      delay_word[DELAY_CSR_W-1:0] = delay;
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? CSR_STEP : CSR_DELAY;
         csr_wdata <= (i == 0) ? step_word : delay_word;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      step_reg  = step;
      delay_reg = delay;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
         input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic test_startup_and_extremes();
      send_word(CMD_READ, '0, '0, 1'b0);
      send_word(CMD_READ, 16'h7fff, 16'h8000, 1'b0);
      send_word(CMD_UNKNOWN, 16'h7fff, 16'h8000, 1'b1);
      send_word(CMD_WRITE, 16'h7fff, 16'h8000, 1'b0);
      send_word(CMD_WRITE, 16'h8000, 16'h7fff, 1'b0);
      send_word(CMD_WRITE, 16'hffff, 16'h0001, 1'b1);
      send_word(CMD_WRITE, 16'hffff, 16'h0001, 1'b0);
      send_word(CMD_WRITE, 16'h5555, 16'haaaa, 1'b0);
      send_word(CMD_WRITE, 16'h0000, 16'hffff, 1'b0);
      // last of these runs out of source frames
      repeat (6) send_word(CMD_READ, '0, '0, 1'b0);
      send_word(CMD_RESTART, 16'h1234, 16'hedcb, 1'b1);
      send_word(CMD_READ, '0, '0, 1'b0);
      send_word(CMD_READ, '0, '0, 1'b0);
      send_word(CMD_WRITE, 16'h8001, 16'h7ffe, 1'b0);
      send_word(CMD_READ, '0, '0, 1'b0);
   endtask

   task automatic test_register_sweeps();
      logic [STEP_CSR_W-1:0]  step;
      logic [DELAY_CSR_W-1:0] delay;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin step = 19'd1;      delay = 13'd0;    end
            1: begin step = 19'd262144; delay = 13'd4096; end
            2: begin step = 19'd0;      delay = 13'd8191; end
            3: begin step = 19'd65536;  delay = 13'd1;    end
            4: begin step = 19'd524287; delay = 13'd4097; end
            5: begin step = 19'd131072; delay = 13'd2;    end
            6: begin step = STEP_RESET; delay = 13'($urandom_range(0, 4096)); end
            default: begin
               step  = 19'($urandom_range(1, 262144));
               delay = 13'($urandom_range(0, 4096));
            end
         endcase
         quiesce();
         set_config(step, delay);
         gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(5, 40);
         stall_pct = (phase % 3 == 1) ? 0 : $urandom_range(2, 15);
         send_word(CMD_RESTART, pick_sample(), pick_sample(), 1'b0);
         repeat (SWEEP_WORDS) send_random_word();
      end
   endtask

   task automatic test_back_to_back();
      quiesce();
      gap_pct   = 0;
      stall_pct = 0;
      // delay saturates to a full ring, so the reader resyncs to frame zero
      set_config(19'd45000, 13'd8191);
      send_word(CMD_RESTART, pick_sample(), pick_sample(), 1'b0);
      repeat (30) send_random_word();
      repeat (6) send_word(CMD_READ, pick_sample(), pick_sample(), 1'b0);
   endtask

   initial begin
      for (int i = 0; i < RING_FRAMES; i++) begin
         ring_left[i]  = '0;
         ring_right[i] = '0;
      end
      wr_count  = '0;
      rd_whole  = '0;
      rd_frac   = '0;
      primed    = 1'b0;
      step_reg  = STEP_RESET;
      delay_reg = DELAY_RESET;
      repeat (12) @(posedge clock);
      reset     <= 1'b0;
      gap_pct   = 20;
      stall_pct = 8;
      test_startup_and_extremes();
      test_register_sweeps();
      test_back_to_back();
      req_valid <= 1'b0;
      while (due_frames.size() != 0) @(posedge clock);
      repeat (4 * SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // result side back-pressure in bursts
   initial begin
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_frames.size() == 0) begin
            $error("result word with no read waiting for it");
            fail_count++;
         end else begin
            want = due_frames.pop_front();
            check_field("left_out", $signed(want.left), rsp_left_out);
            check_field("right_out", $signed(want.right), rsp_right_out);
            check_field("valid_res", want.valid_res, rsp_valid_res);
            check_field("resynced", want.resynced, rsp_resynced);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
